### design/lssd_pkg.sv
`timescale 1ns / 1ps
package lssd_pkg;

  localparam int MAGIC_LEN  = 2;
  localparam int SIZE_BITS  = 32;
  localparam int CFG_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = $clog2(SIZE_BITS);
  localparam int MIDX_W     = (MAGIC_LEN > 1) ? $clog2(MAGIC_LEN) : 1;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_W-1:0] HEADER_SKIP_RST = 16'd54;
  localparam logic [CFG_W-1:0] MAGIC_WORD_RST  = 16'd9002;

  // configuration register indexes
  localparam logic CFG_HEADER_SKIP = 1'b0;
  localparam logic CFG_MAGIC_WORD  = 1'b1;

  // one request handed from the front to the back
  typedef struct packed {
    logic restart;  // frame start seen: back state returns to its reset value
    logic data;     // byte carries a hidden bit
    logic lsb;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // character idx of the magic word; characters above bit 15 are zero
  function automatic logic [BYTE_W-1:0] expected_char(input logic [CFG_W-1:0] word,
                                                      input logic [MIDX_W-1:0] idx);
    int pos;
    pos = MAGIC_LEN - 1 - int'(idx);
    if (pos >= 2 || pos < 0) begin
      return '0;
    end
    return BYTE_W'(word >> (BYTE_W * pos));
  endfunction

endpackage

### design/lssd_front.sv
`timescale 1ns / 1ps
module lssd_front import lssd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       cover_byte,
  input  logic             frame_start,
  input  logic [CFG_W-1:0] header_skip,
  output logic             push,
  output q_entry_t         entry
);

  logic [CFG_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic             hdr_done_r, hdr_done_nxt;
  logic [CFG_W-1:0] cnt_cur;
  logic             done_cur;
  logic             in_hdr;

  always_comb begin
    cnt_cur  = frame_start ? '0   : hdr_cnt_r;
    done_cur = frame_start ? 1'b0 : hdr_done_r;
    in_hdr   = !done_cur && (cnt_cur < header_skip);
    hdr_cnt_nxt  = hdr_cnt_r;
    hdr_done_nxt = hdr_done_r;
    if (accept) begin
      hdr_cnt_nxt  = in_hdr ? cnt_cur + 1'b1 : cnt_cur;
      hdr_done_nxt = !in_hdr;
    end
  end

  // header bytes are dropped unless they have to carry a restart
  assign push          = accept && (!in_hdr || frame_start);
  assign entry.restart = frame_start;
  assign entry.data    = !in_hdr;
  assign entry.lsb     = cover_byte[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r  <= '0;
      hdr_done_r <= 1'b0;
    end else begin
      hdr_cnt_r  <= hdr_cnt_nxt;
      hdr_done_r <= hdr_done_nxt;
    end
  end

endmodule

### design/lssd_queue.sv
`timescale 1ns / 1ps
module lssd_queue import lssd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t status
);

  q_entry_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign status.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### design/lssd_back.sv
`timescale 1ns / 1ps
module lssd_back import lssd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  q_entry_t         head,
  input  q_status_t        q_status,
  output logic             pop,
  input  logic [CFG_W-1:0] magic_word,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_kind,
  output logic             out_is_last,
  output logic             out_magic_match
);

  localparam logic [2:0] PH_MAGIC    = 3'd1;
  localparam logic [2:0] PH_EXT_LEN  = 3'd2;
  localparam logic [2:0] PH_EXT_DATA = 3'd3;
  localparam logic [2:0] PH_PAY_LEN  = 3'd4;
  localparam logic [2:0] PH_PAY_DATA = 3'd5;
  localparam logic [2:0] PH_DONE     = 3'd6;

  logic [2:0]           phase_r, phase_nxt;
  logic [CNT_W-1:0]     bit_cnt_r, bit_cnt_nxt;
  logic [SIZE_BITS-2:0] shift_r, shift_nxt;
  logic [SIZE_BITS-1:0] left_r, left_nxt;
  logic [MIDX_W-1:0]    midx_r, midx_nxt;
  logic                 mok_r, mok_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_mm_r, out_mm_nxt;

  logic [SIZE_BITS-1:0] word;
  logic                 need_long, word_done, emit;

  assign pop = !q_status.empty && (!out_valid_r || out_ready);

  always_comb begin
    // state after an optional restart, before this bit
    phase_nxt   = head.restart ? PH_MAGIC : phase_r;
    bit_cnt_nxt = head.restart ? '0 : bit_cnt_r;
    shift_nxt   = head.restart ? '0 : shift_r;
    left_nxt    = head.restart ? '0 : left_r;
    midx_nxt    = head.restart ? '0 : midx_r;
    mok_nxt     = head.restart ? 1'b1 : mok_r;

    word      = {shift_nxt, head.lsb};
    need_long = (phase_nxt == PH_EXT_LEN) || (phase_nxt == PH_PAY_LEN);
    word_done = need_long ? (bit_cnt_nxt == CNT_W'(SIZE_BITS - 1))
                          : (bit_cnt_nxt == CNT_W'(BYTE_W - 1));
    emit         = 1'b0;
    out_byte_nxt = word[7:0];
    out_kind_nxt = (phase_nxt == PH_PAY_DATA);
    out_last_nxt = (phase_nxt == PH_PAY_DATA) && (left_nxt == SIZE_BITS'(1));
    out_mm_nxt   = mok_nxt;

    if (head.data && phase_nxt != PH_DONE) begin
      if (!word_done) begin
        shift_nxt   = word[SIZE_BITS-2:0];
        bit_cnt_nxt = bit_cnt_nxt + 1'b1;
      end else begin
        shift_nxt   = '0;
        bit_cnt_nxt = '0;
        case (phase_nxt)
          PH_MAGIC: begin
            if (word[7:0] != expected_char(magic_word, midx_nxt)) begin
              mok_nxt = 1'b0;
            end
            if (midx_nxt == MIDX_W'(MAGIC_LEN - 1)) begin
              phase_nxt = PH_EXT_LEN;
            end
            midx_nxt = midx_nxt + 1'b1;
          end
          PH_EXT_LEN: begin
            left_nxt  = word;
            phase_nxt = (word != '0) ? PH_EXT_DATA : PH_PAY_LEN;
          end
          PH_PAY_LEN: begin
            left_nxt  = word;
            phase_nxt = (word != '0) ? PH_PAY_DATA : PH_DONE;
          end
          PH_EXT_DATA: begin
            emit = 1'b1;
            if (left_nxt == SIZE_BITS'(1)) begin
              phase_nxt = PH_PAY_LEN;
            end
            left_nxt = left_nxt - 1'b1;
          end
          PH_PAY_DATA: begin
            emit = 1'b1;
            if (left_nxt == SIZE_BITS'(1)) begin
              phase_nxt = PH_DONE;
            end
            left_nxt = left_nxt - 1'b1;
          end
          default: begin
            phase_nxt = PH_DONE;
          end
        endcase
      end
    end

    if (pop && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_byte_r <= out_byte_nxt;
      out_kind_r <= out_kind_nxt;
      out_last_r <= out_last_nxt;
      out_mm_r   <= out_mm_nxt;
    end
    if (pop) begin
      shift_r <= shift_nxt;
      left_r  <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MAGIC;
      bit_cnt_r   <= '0;
      midx_r      <= '0;
      mok_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r   <= phase_nxt;
        bit_cnt_r <= bit_cnt_nxt;
        midx_r    <= midx_nxt;
        mok_r     <= mok_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_kind        = out_kind_r;
  assign out_is_last     = out_last_r;
  assign out_magic_match = out_mm_r;

endmodule

### design/lsb_stego_stream_decoder_core.sv
`timescale 1ns / 1ps
// A hidden byte is registered into the output when the queue entry with its last bit is popped.
// Throughput: 1 cover byte per cycle while in_ready is high; the back end pops one queue entry
// per cycle while the output register is free or draining, the 4-entry queue absorbs stalls.
// Reset (rst_n low, synchronous): header_skip = 54, magic_word = 9002, decoder back in
// header skip, queue and output empty. No clearing pass; in_ready is high right after reset.
module lsb_stego_stream_decoder_core import lssd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_cover_byte,
  input  logic             in_frame_start,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_kind,
  output logic             out_is_last,
  output logic             out_magic_match,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0] header_skip_r;
  logic [CFG_W-1:0] magic_word_r;
  logic             accept;
  logic             push;
  logic             pop;
  q_entry_t         push_entry;
  q_entry_t         head;
  q_status_t        q_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_skip_r <= HEADER_SKIP_RST;
      magic_word_r  <= MAGIC_WORD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_SKIP: header_skip_r <= cfg_wdata;
        CFG_MAGIC_WORD:  magic_word_r  <= cfg_wdata;
        default:         header_skip_r <= header_skip_r;
      endcase
    end
  end

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  lssd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cover_byte  (in_cover_byte),
    .frame_start (in_frame_start),
    .header_skip (header_skip_r),
    .push        (push),
    .entry       (push_entry)
  );

  lssd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  lssd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_status        (q_status),
    .pop             (pop),
    .magic_word      (magic_word_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_kind        (out_kind),
    .out_is_last     (out_is_last),
    .out_magic_match (out_magic_match)
  );

`ifndef SYNTHESIS
  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty together");

  a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_is_last || out_kind))
    else $error("last flag on an extension byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("not idle after reset");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.empty |-> !pop)
    else $error("pop from empty queue");
`endif

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import lssd_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int NO_LIMIT   = 32'h3fff_ffff;
  localparam int SETTLE     = 8;

  typedef enum logic [2:0] {
    ST_HEADER, ST_MAGIC, ST_EXT_LEN, ST_EXT_DATA, ST_PAY_LEN, ST_PAY_DATA, ST_DONE
  } dec_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic       last;
    logic       match;
  } hidden_byte_t;

  class hidden_byte_board;
    logic [CFG_W-1:0]     skip_len;
    logic [CFG_W-1:0]     magic_cfg;
    dec_phase_t           ph;
    logic [15:0]          hdr_seen;
    int unsigned          bits_in;
    logic [SIZE_BITS-1:0] shreg;
    logic [SIZE_BITS-1:0] remaining;
    int                   char_idx;
    logic                 magic_good;
    hidden_byte_t         pending_bytes[$];
    int                   n_fail;
    int                   n_expected;
    int                   n_checked;
    int                   n_payload;
    int                   n_last;
    int                   n_bad_magic;

    function new();
      skip_len    = HEADER_SKIP_RST;
      magic_cfg   = MAGIC_WORD_RST;
      n_fail      = 0;
      n_expected  = 0;
      n_checked   = 0;
      n_payload   = 0;
      n_last      = 0;
      n_bad_magic = 0;
      restart();
    endfunction

    function void restart();
      ph         = ST_HEADER;
      hdr_seen   = '0;
      bits_in    = 0;
      shreg      = '0;
      remaining  = '0;
      char_idx   = 0;
      magic_good = 1'b1;
    endfunction

    function void set_reg(input logic idx, input logic [CFG_W-1:0] val);
      if (idx == CFG_HEADER_SKIP) begin
        skip_len = val;
      end else if (idx == CFG_MAGIC_WORD) begin
        magic_cfg = val;
      end
    endfunction

    // first character sits in the upper byte; anything above bit 15 reads as zero
    function logic [7:0] magic_char(input int idx);
      int pos;
      pos = MAGIC_LEN - 1 - idx;
      if (pos >= 2) begin
        return 8'h00;
      end
      return magic_cfg[8*pos +: 8];
    endfunction

    function void note_cover(input logic [7:0] cb, input logic fs);
      int unsigned          need;
      logic [SIZE_BITS-1:0] val;
      hidden_byte_t         hb;
      if (fs) begin
        restart();
      end
      if (ph == ST_HEADER) begin
        if (hdr_seen < skip_len) begin
          hdr_seen++;
          return;
        end
        ph = ST_MAGIC;
      end
      if (ph == ST_DONE) begin
        return;
      end
      need  = (ph == ST_EXT_LEN || ph == ST_PAY_LEN) ? SIZE_BITS : 8;
      shreg = {shreg[SIZE_BITS-2:0], cb[0]};
      bits_in++;
      if (bits_in < need) begin
        return;
      end
      val = '0;
      val[7:0] = shreg[7:0];
      if (need != 8) begin
        val = shreg;
      end
      bits_in = 0;
      shreg   = '0;
      case (ph)
        ST_MAGIC: begin
          if (val[7:0] != magic_char(char_idx)) begin
            magic_good = 1'b0;
          end
          char_idx++;
          if (char_idx >= MAGIC_LEN) begin
            ph = ST_EXT_LEN;
          end
        end
        ST_EXT_LEN: begin
          remaining = val;
          ph = (val != 0) ? ST_EXT_DATA : ST_PAY_LEN;
        end
        ST_PAY_LEN: begin
          remaining = val;
          ph = (val != 0) ? ST_PAY_DATA : ST_DONE;
        end
        ST_EXT_DATA, ST_PAY_DATA: begin
          hb.data  = val[7:0];
          hb.kind  = (ph == ST_PAY_DATA);
          hb.last  = (ph == ST_PAY_DATA) && (remaining == 1);
          hb.match = magic_good;
          pending_bytes.push_back(hb);
          n_expected++;
          remaining--;
          if (remaining == 0) begin
            ph = (ph == ST_PAY_DATA) ? ST_DONE : ST_PAY_LEN;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_hidden(input logic [7:0] d, input logic k, input logic l,
                               input logic m);
      hidden_byte_t want;
      if (pending_bytes.size() == 0) begin
        n_fail++;
        $display("%0t: hidden byte %02h (kind %0b last %0b match %0b) with none expected",
                 $time, d, k, l, m);
        return;
      end
      want = pending_bytes.pop_front();
      n_checked++;
      if (want.kind) n_payload++;
      if (want.last) n_last++;
      if (!want.match) n_bad_magic++;
      if (want.data !== d) begin
        n_fail++;
        $display("%0t: out_byte expected %02h, got %02h", $time, want.data, d);
      end
      if (want.kind !== k) begin
        n_fail++;
        $display("%0t: out_kind expected %0b, got %0b", $time, want.kind, k);
      end
      if (want.last !== l) begin
        n_fail++;
        $display("%0t: out_is_last expected %0b, got %0b", $time, want.last, l);
      end
      if (want.match !== m) begin
        n_fail++;
        $display("%0t: out_magic_match expected %0b, got %0b", $time, want.match, m);
      end
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_cover_byte = 8'h00;
  logic             in_frame_start = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_byte;
  logic             out_kind;
  logic             out_is_last;
  logic             out_magic_match;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_HEADER_SKIP;
  logic [CFG_W-1:0] cfg_wdata = '0;

  hidden_byte_board board = new();

  int          cur_skip = HEADER_SKIP_RST;
  logic [15:0] cur_magic = MAGIC_WORD_RST;
  int          n_items = 0;
  int          n_settings = 0;
  int          burst_left = 0;
  int          frame_budget = NO_LIMIT;
  logic        fs_pending = 1'b0;
  int          idle_cycles = 0;
  int          rx_mode = 0;
  int          rx_hold = 0;
  int          rx_pos = 0;
  logic [7:0]  rx_pat = 8'hff;

  lsb_stego_stream_decoder_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cover_byte   (in_cover_byte),
    .in_frame_start  (in_frame_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_kind        (out_kind),
    .out_is_last     (out_is_last),
    .out_magic_match (out_magic_match),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver: changes its stall habit every so often, from always ready to mostly stalled
  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_hold = $urandom_range(20, 200);
      rx_pat  = 8'($urandom) | 8'h01;
    end else begin
      rx_hold--;
    end
    rx_pos = (rx_pos + 1) % 8;
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= rx_pat[rx_pos];
      2:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        board.set_reg(cfg_index, cfg_wdata);
      end
      if (in_valid && in_ready) begin
        board.note_cover(in_cover_byte, in_frame_start);
      end
      if (out_valid && out_ready) begin
        board.check_hidden(out_byte, out_kind, out_is_last, out_magic_match);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic put_byte(input logic [7:0] b);
    if (frame_budget <= 0) begin
      return;
    end
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                               : $urandom_range(1, 12);
    end
    in_valid       <= 1'b1;
    in_cover_byte  <= b;
    in_frame_start <= fs_pending;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fs_pending = 1'b0;
    burst_left--;
    frame_budget--;
    n_items++;
  endtask

  task automatic put_bits(input logic [31:0] v, input int n);
    logic [7:0] r;
    for (int i = n - 1; i >= 0; i--) begin
      r    = 8'($urandom);
      r[0] = v[i];
      put_byte(r);
    end
  endtask

  // wait out every expected byte, then let the pipeline settle on bytes that carry none
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [15:0] skip, input logic [15:0] magic);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HEADER_SKIP;
    cfg_wdata <= skip;
    @(posedge clk);
    cfg_index <= CFG_MAGIC_WORD;
    cfg_wdata <= magic;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_skip  = skip;
    cur_magic = magic;
    n_settings++;
  endtask

  task automatic send_frame(input logic [15:0] magic, input logic [31:0] ext_len,
                            input logic [31:0] pay_len, input int tail, input bit split);
    int keep;
    fs_pending = 1'b1;
    if (split && cur_skip >= 2) begin
      keep = $urandom_range(1, cur_skip - 1);
      repeat (keep) put_byte(8'($urandom));
      // lower the skip to or below what the decoder has already passed
      drain();
      write_cfg(16'($urandom_range(0, keep)), cur_magic);
    end else begin
      repeat (cur_skip) put_byte(8'($urandom));
    end
    put_bits(magic, 8 * MAGIC_LEN);
    put_bits(ext_len, SIZE_BITS);
    for (longint j = 0; j < ext_len && frame_budget > 0; j++) begin
      put_bits(32'($urandom), 8);
    end
    put_bits(pay_len, SIZE_BITS);
    for (longint j = 0; j < pay_len && frame_budget > 0; j++) begin
      put_bits(32'($urandom), 8);
    end
    repeat (tail) put_byte(8'($urandom));
  endtask

  task automatic random_frame(input int budget, input bit huge, input bit split);
    logic [15:0] m;
    logic [31:0] e;
    logic [31:0] p;
    m = ($urandom_range(0, 3) != 0) ? cur_magic : 16'($urandom);
    e = ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom_range(1, 3));
    p = ($urandom_range(0, 5) == 0) ? 32'd0 : 32'($urandom_range(1, 10));
    if (huge) begin
      if ($urandom_range(0, 1) == 1) begin
        e = $urandom;
      end else begin
        e = 32'd0;
        p = $urandom;
      end
    end
    frame_budget = budget;
    send_frame(m, e, p, $urandom_range(0, 4), split);
    frame_budget = NO_LIMIT;
  endtask

  task automatic send_noise();
    repeat ($urandom_range(20, 60)) begin
      fs_pending = ($urandom_range(0, 19) == 0);
      put_byte(8'($urandom));
    end
  endtask

  initial begin
    int sel;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // a clean frame under the reset register values
    send_frame(cur_magic, 32'd2, 32'd3, 2, 1'b0);
    drain();

    // widest header skip: every byte here is swallowed, frame starts included
    write_cfg(16'hffff, 16'hffff);
    fs_pending = 1'b1;
    put_byte(8'h00);
    put_byte(8'hff);
    put_byte(8'h01);
    put_byte(8'hfe);
    fs_pending = 1'b1;
    put_byte(8'haa);
    put_byte(8'h55);
    put_byte(8'h80);
    put_byte(8'h7f);
    drain();

    while (n_items < 600) begin
      case (n_settings)
        2: write_cfg(16'd0, 16'h0000);
        3: write_cfg(16'd3, 16'hffff);
        default: begin
          sel = $urandom_range(0, 7);
          write_cfg((sel == 0) ? 16'd0 :
                    (sel <= 5) ? 16'($urandom_range(1, 4)) :
                    (sel == 6) ? 16'($urandom_range(5, 20)) : 16'd54,
                    ($urandom_range(0, 5) == 4) ? 16'h0000 :
                    ($urandom_range(0, 5) == 5) ? 16'hffff : 16'($urandom));
        end
      endcase
      repeat ($urandom_range(1, 3)) begin
        sel = $urandom_range(0, 9);
        if (sel <= 5) begin
          random_frame(NO_LIMIT, 1'b0, 1'b0);
        end else if (sel == 6) begin
          random_frame(NO_LIMIT, 1'b0, 1'b1);
        end else if (sel == 7) begin
          // frame cut short by the next frame start
          random_frame($urandom_range(1, cur_skip + 100), 1'b0, 1'b0);
        end else if (sel == 8) begin
          random_frame(cur_skip + 8 * MAGIC_LEN + SIZE_BITS + $urandom_range(8, 60),
                       1'b1, 1'b0);
        end else begin
          send_noise();
        end
      end
      drain();
    end

    $display("Sent %0d cover bytes under %0d register settings (header skip 0 to 65535).",
             n_items, n_settings);
    $display("Checked %0d hidden bytes: %0d payload, %0d final, %0d under a bad magic word.",
             board.n_checked, board.n_payload, board.n_last, board.n_bad_magic);
    if (board.n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### lsb_stego_stream_decoder_core.f
design/lssd_pkg.sv
design/lssd_front.sv
design/lssd_queue.sv
design/lssd_back.sv
design/lsb_stego_stream_decoder_core.sv
dv/testbench.sv
